// File: sv/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    OP_ADD_FRONT  = 4'd0,
    OP_ADD_BACK   = 4'd1,
    OP_DROP_FRONT = 4'd2,
    OP_DROP_BACK  = 4'd3,
    OP_DROP_VALUE = 4'd4,
    OP_CLEAR      = 4'd5,
    OP_LIST_ALL   = 4'd6,
    OP_LIST_FIRST = 4'd7,
    OP_LIST_LAST  = 4'd8
  } bdq_op_e;

  // ST_EMPTY also reports a value drop that found no match
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } bdq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_LREAD,
    S_LEMIT,
    S_SREAD,
    S_SCMP,
    S_CREAD,
    S_CWRITE
  } bdq_state_e;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              has_element;
    bdq_status_e       status;
    logic              last;
  } bdq_res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ELEM_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } bdq_mem_req_t;

endpackage

// File: sv/bdq_store.sv
module bdq_store
  import bdq_pkg::*;
(
  input  logic              clk_i,
  input  bdq_mem_req_t      req_i,
  output logic [ELEM_W-1:0] rd_data_o
);

  logic [ELEM_W-1:0] mem [DEPTH];
  logic [ELEM_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/bdq_ctrl.sv
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        op_i,
  input  logic [ELEM_W-1:0] arg_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bdq_res_t          res_o,
  output bdq_mem_req_t      mem_o,
  input  logic [ELEM_W-1:0] rd_data_i
);

  bdq_state_e        state_q, state_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ELEM_W-1:0] arg_q, arg_d;
  bdq_status_e       status_q, status_d;

  logic              full, empty;
  logic [CNT_W-1:0]  clip_n, list_n;
  logic [CNT_W-1:0]  off;
  logic [IDX_W-1:0]  ring_addr;
  logic              is_add;

  assign full  = (occ_q == CNT_W'(DEPTH));
  assign empty = (occ_q == '0);

  // Clip a signed count to the occupancy; negative selects nothing
  always_comb begin
    if (arg_i[ELEM_W-1]) begin
      clip_n = '0;
    end else if ((|arg_i[ELEM_W-2:CNT_W]) || (arg_i[CNT_W-1:0] > occ_q)) begin
      clip_n = occ_q;
    end else begin
      clip_n = arg_i[CNT_W-1:0];
    end
  end

  assign list_n = (op_i == OP_LIST_ALL) ? occ_q : clip_n;

  // Shared ring address adder
  assign off       = (state_q == S_CREAD) ? idx_q + CNT_W'(1) : idx_q;
  assign ring_addr = base_q + off[IDX_W-1:0];

  assign is_add = (op_i == OP_ADD_FRONT) || (op_i == OP_ADD_BACK);

  // Next state and datapath
  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    base_d   = base_q;
    occ_d    = occ_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    arg_d    = arg_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          arg_d    = arg_i;
          status_d = ST_OK;
          idx_d    = '0;
          base_d   = front_q;
          state_d  = S_RESP;
          case (op_i)
            OP_ADD_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                front_d = front_q - IDX_W'(1);
                occ_d   = occ_q + CNT_W'(1);
              end
            end
            OP_ADD_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                occ_d = occ_q + CNT_W'(1);
              end
            end
            OP_DROP_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                front_d = front_q + IDX_W'(1);
                occ_d   = occ_q - CNT_W'(1);
              end
            end
            OP_DROP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                occ_d = occ_q - CNT_W'(1);
              end
            end
            OP_DROP_VALUE: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_SREAD;
              end
            end
            OP_CLEAR: begin
              occ_d   = '0;
              front_d = '0;
            end
            OP_LIST_ALL, OP_LIST_FIRST, OP_LIST_LAST: begin
              cnt_d = list_n;
              if (op_i == OP_LIST_LAST) begin
                base_d = front_q + IDX_W'(occ_q - list_n);
              end
              if (list_n != '0) begin
                state_d = S_LREAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_LREAD: state_d = S_LEMIT;
      S_LEMIT: begin
        if (res_ready_i) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = (idx_q + CNT_W'(1) == cnt_q) ? S_IDLE : S_LREAD;
        end
      end
      S_SREAD: state_d = S_SCMP;
      S_SCMP: begin
        if (rd_data_i == arg_q) begin
          if (idx_q + CNT_W'(1) < occ_q) begin
            state_d = S_CREAD;
          end else begin
            occ_d   = occ_q - CNT_W'(1);
            state_d = S_RESP;
          end
        end else begin
          idx_d = idx_q + CNT_W'(1);
          if (idx_q + CNT_W'(1) == occ_q) begin
            status_d = ST_EMPTY;
            state_d  = S_RESP;
          end else begin
            state_d = S_SREAD;
          end
        end
      end
      S_CREAD: state_d = S_CWRITE;
      S_CWRITE: begin
        idx_d = idx_q + CNT_W'(1);
        if (idx_q + CNT_W'(2) < occ_q) begin
          state_d = S_CREAD;
        end else begin
          occ_d   = occ_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: handshake, result and store access
  always_comb begin
    in_ready_o        = 1'b0;
    res_valid_o       = 1'b0;
    res_o.element     = '0;
    res_o.has_element = 1'b0;
    res_o.status      = status_q;
    res_o.last        = 1'b1;
    mem_o.we          = 1'b0;
    mem_o.waddr       = ring_addr;
    mem_o.wdata       = rd_data_i;
    mem_o.re          = 1'b0;
    mem_o.raddr       = ring_addr;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && is_add && !full) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = arg_i;
          mem_o.waddr = (op_i == OP_ADD_FRONT) ? front_q - IDX_W'(1)
                                               : front_q + occ_q[IDX_W-1:0];
        end
      end
      S_RESP: res_valid_o = 1'b1;
      S_LEMIT: begin
        res_valid_o       = 1'b1;
        res_o.element     = rd_data_i;
        res_o.has_element = 1'b1;
        res_o.status      = ST_OK;
        res_o.last        = (idx_q + CNT_W'(1) == cnt_q);
      end
      S_LREAD, S_SREAD, S_CREAD: mem_o.re = 1'b1;
      S_CWRITE: mem_o.we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      occ_q    <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      base_q   <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      occ_q    <= occ_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      base_q   <= base_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arg_q <= arg_d;
  end

endmodule

// File: sv/bounded_deque_engine.sv
// Sequencing: a single-result command is accepted, its result is offered from the sequencer's
// response state and then registered in the output register. A listing reads and then emits
// each element in turn; a value drop reads and compares each entry searched, then reads and
// writes each entry moved forward. The sequencer takes one command at a time.
// Reset: rst_ni is asynchronous, active low; the queue comes up empty with the front at slot 0.
// The store itself is not cleared: only live entries are ever read.
module bounded_deque_engine
  import bdq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] argument
  input  logic [3:0]  s_axis_tuser,   // [3:0] operation
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] element, [33:32] status, [39:34] zero
  output logic [0:0]  m_axis_tuser,   // [0] has_element
  output logic        m_axis_tlast    // last result of the command
);

  bdq_res_t          res;
  logic              res_valid, res_ready;
  bdq_mem_req_t      mem_req;
  logic [ELEM_W-1:0] rd_data;

  bdq_res_t out_q;
  logic     out_valid_q;

  // Sequencer: decodes each command and walks the ring through the shared address adder
  // and comparator, one store access per step.
  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .arg_i       (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem_req),
    .rd_data_i   (rd_data)
  );

  // Ring store: one write and one registered read per cycle
  bdq_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Output register: take a new result when empty or when the current one leaves this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; hold it while the transaction stalls
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.element};
  assign m_axis_tuser  = out_q.has_element;
  assign m_axis_tlast  = out_q.last;

  // Only listings produce more than one result, so an unmarked result carries an element
  a_multi_is_listing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0])
    else $error("non-final result without an element");

  // Listed elements always report a good status
  a_listed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[33:32] == ST_OK)
    else $error("listed element with error status");

  // The sequencer offers no result while it waits for a command
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid)
    else $error("result offered while idle");

  // A full-queue add never comes with an element and always ends the command
  a_full_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.status == ST_FULL |-> res.last && !res.has_element)
    else $error("malformed full-queue result");

endmodule
